// ===== hw/rtl/tdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime test: shared definitions
// Word width, divider counter sizing and the request/response words that
// pass between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Width of the tested value (supported range 8 to 64).
    localparam int WIDTH = 32;

    // Step counter of the bit-serial divider: counts WIDTH-1 down to 0.
    localparam int CNT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0] div_cnt_t;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    // Response from the divider, valid when done is high.
    typedef struct packed {
        logic  busy;
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

endpackage

// ===== hw/rtl/tdpt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime test: channel interfaces
// Valid/ready channels for the value word in and the verdict word out.
// ----------------------------------------------------------------------------
interface tdpt_in_if;
    logic               valid;
    logic               ready;
    tdpt_pkg::word_t    value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_out_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== hw/rtl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps
// Values 0, 1, 2 and even values are decided without a division. An odd
// value runs one division on the shared divider for each odd divisor tried,
// from 3 up to the first divisor that exceeds the quotient or divides evenly
// (worst case about 2^(WIDTH/2 - 1) divisors), then registers the verdict.
// Throughput: one word at a time; a new word is taken once the verdict is
// registered. Reset (rst_n, asynchronous) empties the block at once.
// ----------------------------------------------------------------------------
// Trial-division prime test: top level
// Sequencer that screens trivial values and drives one shared divider over
// the odd trial divisors, then reports whether the value is prime.
// ----------------------------------------------------------------------------
module trial_division_prime_test
(
    input  logic            clk,
    input  logic            rst_n,
    tdpt_in_if.sink         in_ch,
    tdpt_out_if.source      out_ch
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    tdpt_pkg::word_t        value_reg;
    tdpt_pkg::word_t        dsr_reg;
    logic                   prime_reg;
    logic                   out_valid_reg;
    logic                   out_prime_reg;
    tdpt_pkg::div_req_t     div_req;
    tdpt_pkg::div_rsp_t     div_rsp;
    logic                   in_take;
    logic                   out_free;

    assign in_take  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // Shared divider.
    assign div_req.start    = (state_reg == ST_DIV_START);
    assign div_req.dividend = value_reg;
    assign div_req.divisor  = dsr_reg;

    tdpt_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer with the output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            dsr_reg       <= '0;
            prime_reg     <= 1'b0;
            out_prime_reg <= 1'b0;
        end
        else
        begin
            // The finish state decides the output valid itself.
            if (out_valid_reg && out_ch.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        value_reg <= in_ch.value;
                        dsr_reg   <= tdpt_pkg::word_t'(3);
                        // Trivial cases need no division.
                        if (in_ch.value <= tdpt_pkg::word_t'(1))
                        begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end
                        else if (in_ch.value == tdpt_pkg::word_t'(2))
                        begin
                            prime_reg <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                        else if (!in_ch.value[0])
                        begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        // Divisor beyond the square root: no factor found.
                        if (dsr_reg > div_rsp.quotient)
                        begin
                            prime_reg <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                        else if (div_rsp.remainder == '0)
                        begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            dsr_reg   <= dsr_reg + tdpt_pkg::word_t'(2);
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_prime_reg <= prime_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.is_prime = out_prime_reg;

    // A word is only taken while the divider is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> !div_rsp.busy)
    else $error("word accepted while the divider is busy");

    // Divider results arrive only while the sequencer waits for them.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

    // Trial divisors are always odd and at least three.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (dsr_reg[0] && (dsr_reg >= tdpt_pkg::word_t'(3))))
    else $error("trial divisor is even or below three");

endmodule

// ===== hw/rtl/tdpt_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime test: shared divider
// Restoring bit-serial divider, one quotient bit per cycle. Gives quotient
// and remainder when the step count runs out. The divisor must be non-zero.
// ----------------------------------------------------------------------------
module tdpt_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  tdpt_pkg::div_req_t  req,
    output tdpt_pkg::div_rsp_t  rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    tdpt_pkg::div_cnt_t     cnt_reg, cnt_next;
    tdpt_pkg::word_t        rem_reg, rem_next;
    tdpt_pkg::word_t        quo_reg, quo_next;
    tdpt_pkg::word_t        dsr_reg, dsr_next;
    logic [tdpt_pkg::WIDTH:0] trial;
    logic                   neg;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {rem_reg, quo_reg[tdpt_pkg::WIDTH-1]} - {1'b0, dsr_reg};
    assign neg   = trial[tdpt_pkg::WIDTH];

    // Next-state logic for one restoring step.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = tdpt_pkg::div_cnt_t'(tdpt_pkg::WIDTH - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = neg ? {rem_reg[tdpt_pkg::WIDTH-2:0], quo_reg[tdpt_pkg::WIDTH-1]}
                           : trial[tdpt_pkg::WIDTH-1:0];
            quo_next = {quo_reg[tdpt_pkg::WIDTH-2:0], ~neg};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
